@@ sv/ycbcr_to_rgb_pixel_macros.svh @@
// ---------------------------------------------------------------------------
// ycbcr_to_rgb_pixel_macros.svh
// Assertion macros for the ycbcr to rgb pixel converter; empty when
// NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef YCBCR_TO_RGB_PIXEL_MACROS_SVH
`define YCBCR_TO_RGB_PIXEL_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define Y2R_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define Y2R_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define Y2R_ASSERT_IMPLY(label, ante, cons, msg)
`define Y2R_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ sv/y2r_pkg.sv @@
// ---------------------------------------------------------------------------
// y2r_pkg
// Types, register codes and fixed-point coefficient tables of the
// ycbcr to rgb pixel converter.
// ---------------------------------------------------------------------------
package y2r_pkg;

	// fixed-point format of the coefficients
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int CSAMP_W = 9;
	localparam int PROD_W = CSAMP_W + COEF_W + 1;
	localparam int ACC_W = PROD_W + 2;

	// configuration register indexes and widths
	localparam int REG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [REG_IDX_W-1:0] REG_STANDARD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANGE = 2'd1;

	// color standard and range codes
	localparam logic [3:0] STD_BT601_A = 4'd2;
	localparam logic [3:0] STD_BT601_B = 4'd4;
	localparam logic [3:0] STD_BT2020 = 4'd6;
	localparam logic [3:0] STD_RESET = 4'd1;
	localparam logic [1:0] RANGE_FULL = 2'd1;
	localparam logic [1:0] RANGE_RESET = 2'd2;

	// sample offsets and output limit
	localparam logic [8:0] LUMA_OFS = 9'd16;
	localparam logic [8:0] CHROMA_ZERO = 9'd128;
	localparam int PIX_MAX = 255;

	// luma weights in units of 1/10000
	localparam longint WR_709 = 2126;
	localparam longint WB_709 = 722;
	localparam longint WR_601 = 2990;
	localparam longint WB_601 = 1140;
	localparam longint WR_2020 = 2627;
	localparam longint WB_2020 = 593;

	localparam longint ONE_Q = longint'(1) << COEF_FRAC_BITS;
	localparam longint LUMA_LIM = (255 * ONE_Q + 109) / 219;

	// bt.709 set, full (_F) and limited (_L) range
	localparam longint K709_RCR_F = (2 * (10000 - WR_709) * ONE_Q + 5000) / 10000;
	localparam longint K709_BCB_F = (2 * (10000 - WB_709) * ONE_Q + 5000) / 10000;
	localparam longint K709_GCR_F = (2 * WR_709 * (10000 - WR_709) * ONE_Q
		+ (10000 - WR_709 - WB_709) * 5000) / ((10000 - WR_709 - WB_709) * 10000);
	localparam longint K709_GCB_F = (2 * WB_709 * (10000 - WB_709) * ONE_Q
		+ (10000 - WR_709 - WB_709) * 5000) / ((10000 - WR_709 - WB_709) * 10000);
	localparam longint K709_RCR_L =
		(2 * (10000 - WR_709) * 255 * ONE_Q + 1120000) / 2240000;
	localparam longint K709_BCB_L =
		(2 * (10000 - WB_709) * 255 * ONE_Q + 1120000) / 2240000;
	localparam longint K709_GCR_L = (2 * WR_709 * (10000 - WR_709) * 255 * ONE_Q
		+ (10000 - WR_709 - WB_709) * 1120000) / ((10000 - WR_709 - WB_709) * 2240000);
	localparam longint K709_GCB_L = (2 * WB_709 * (10000 - WB_709) * 255 * ONE_Q
		+ (10000 - WR_709 - WB_709) * 1120000) / ((10000 - WR_709 - WB_709) * 2240000);

	// bt.601 set
	localparam longint K601_RCR_F = (2 * (10000 - WR_601) * ONE_Q + 5000) / 10000;
	localparam longint K601_BCB_F = (2 * (10000 - WB_601) * ONE_Q + 5000) / 10000;
	localparam longint K601_GCR_F = (2 * WR_601 * (10000 - WR_601) * ONE_Q
		+ (10000 - WR_601 - WB_601) * 5000) / ((10000 - WR_601 - WB_601) * 10000);
	localparam longint K601_GCB_F = (2 * WB_601 * (10000 - WB_601) * ONE_Q
		+ (10000 - WR_601 - WB_601) * 5000) / ((10000 - WR_601 - WB_601) * 10000);
	localparam longint K601_RCR_L =
		(2 * (10000 - WR_601) * 255 * ONE_Q + 1120000) / 2240000;
	localparam longint K601_BCB_L =
		(2 * (10000 - WB_601) * 255 * ONE_Q + 1120000) / 2240000;
	localparam longint K601_GCR_L = (2 * WR_601 * (10000 - WR_601) * 255 * ONE_Q
		+ (10000 - WR_601 - WB_601) * 1120000) / ((10000 - WR_601 - WB_601) * 2240000);
	localparam longint K601_GCB_L = (2 * WB_601 * (10000 - WB_601) * 255 * ONE_Q
		+ (10000 - WR_601 - WB_601) * 1120000) / ((10000 - WR_601 - WB_601) * 2240000);

	// bt.2020 set
	localparam longint K2020_RCR_F = (2 * (10000 - WR_2020) * ONE_Q + 5000) / 10000;
	localparam longint K2020_BCB_F = (2 * (10000 - WB_2020) * ONE_Q + 5000) / 10000;
	localparam longint K2020_GCR_F = (2 * WR_2020 * (10000 - WR_2020) * ONE_Q
		+ (10000 - WR_2020 - WB_2020) * 5000) / ((10000 - WR_2020 - WB_2020) * 10000);
	localparam longint K2020_GCB_F = (2 * WB_2020 * (10000 - WB_2020) * ONE_Q
		+ (10000 - WR_2020 - WB_2020) * 5000) / ((10000 - WR_2020 - WB_2020) * 10000);
	localparam longint K2020_RCR_L =
		(2 * (10000 - WR_2020) * 255 * ONE_Q + 1120000) / 2240000;
	localparam longint K2020_BCB_L =
		(2 * (10000 - WB_2020) * 255 * ONE_Q + 1120000) / 2240000;
	localparam longint K2020_GCR_L = (2 * WR_2020 * (10000 - WR_2020) * 255 * ONE_Q
		+ (10000 - WR_2020 - WB_2020) * 1120000)
		/ ((10000 - WR_2020 - WB_2020) * 2240000);
	localparam longint K2020_GCB_L = (2 * WB_2020 * (10000 - WB_2020) * 255 * ONE_Q
		+ (10000 - WR_2020 - WB_2020) * 1120000)
		/ ((10000 - WR_2020 - WB_2020) * 2240000);

	typedef logic [COEF_W-1:0] coef_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		coef_t luma;
		coef_t rcr;
		coef_t bcb;
		coef_t gcr;
		coef_t gcb;
	} coef_set_t;

	typedef struct packed {
		logic [7:0] luma_code;
		logic [7:0] cb_code;
		logic [7:0] cr_code;
	} ycc_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// coefficient set for a standard code and range code
	function automatic coef_set_t coef_select(input logic [3:0] std, input logic [1:0] rng);
		coef_set_t cs;
		logic full;
		full = (rng == RANGE_FULL);
		cs.luma = full ? COEF_W'(ONE_Q) : COEF_W'(LUMA_LIM);
		if (std == STD_BT2020) begin
			cs.rcr = full ? COEF_W'(K2020_RCR_F) : COEF_W'(K2020_RCR_L);
			cs.bcb = full ? COEF_W'(K2020_BCB_F) : COEF_W'(K2020_BCB_L);
			cs.gcr = full ? COEF_W'(K2020_GCR_F) : COEF_W'(K2020_GCR_L);
			cs.gcb = full ? COEF_W'(K2020_GCB_F) : COEF_W'(K2020_GCB_L);
		end else if (std inside {STD_BT601_A, STD_BT601_B}) begin
			cs.rcr = full ? COEF_W'(K601_RCR_F) : COEF_W'(K601_RCR_L);
			cs.bcb = full ? COEF_W'(K601_BCB_F) : COEF_W'(K601_BCB_L);
			cs.gcr = full ? COEF_W'(K601_GCR_F) : COEF_W'(K601_GCR_L);
			cs.gcb = full ? COEF_W'(K601_GCB_F) : COEF_W'(K601_GCB_L);
		end else begin
			cs.rcr = full ? COEF_W'(K709_RCR_F) : COEF_W'(K709_RCR_L);
			cs.bcb = full ? COEF_W'(K709_BCB_F) : COEF_W'(K709_BCB_L);
			cs.gcr = full ? COEF_W'(K709_GCR_F) : COEF_W'(K709_GCR_L);
			cs.gcb = full ? COEF_W'(K709_GCB_F) : COEF_W'(K709_GCB_L);
		end
		return cs;
	endfunction

endpackage

@@ sv/y2r_if.sv @@
// ---------------------------------------------------------------------------
// y2r_if
// Valid/ready stream channels of the converter: ycbcr pixels in,
// rgb pixels out.
// ---------------------------------------------------------------------------
interface y2r_ycc_if;
	import y2r_pkg::*;

	logic valid;
	logic ready;
	ycc_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface y2r_rgb_if;
	import y2r_pkg::*;

	logic valid;
	logic ready;
	rgb_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/ycbcr_to_rgb_pixel.sv @@
// ---------------------------------------------------------------------------
// ycbcr_to_rgb_pixel
// Pipelined ycbcr to rgb pixel converter with selectable luma weights and
// full or limited input range.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the output does not stall: the work runs
// through four register stages (coefficient lookup, multiply, sum, round and
// clamp), the last of which is the output register. Each stage moves on when
// it is empty or the stage after it moves, so bubbles close up and a stalled
// output holds its beat while the earlier stages keep filling. Write the
// standard and range registers only while no pixel is in flight; writes to
// indexes above 1 are ignored.
`include "ycbcr_to_rgb_pixel_macros.svh"

module ycbcr_to_rgb_pixel
	import y2r_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	y2r_ycc_if.sink               ycc,
	y2r_rgb_if.source             rgb
);

	typedef logic signed [CSAMP_W-1:0] samp_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	logic [3:0] std_q;
	logic [1:0] rng_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv1, adv2, adv3, adv4;

	coef_set_t cf_s1;
	samp_t y_s1, cb_s1, cr_s1;
	prod_t lt_s2, rcr_s2, bcb_s2, gcr_s2, gcb_s2;
	acc_t accr_s3, accg_s3, accb_s3;
	rgb_t rgb_s4;

	samp_t y_in, cb_in, cr_in;
	logic [7:0] red_c, green_c, blue_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_q <= STD_RESET;
			rng_q <= RANGE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STANDARD: std_q <= cfg_data[3:0];
				REG_RANGE:    rng_q <= cfg_data[1:0];
				default:      ;
			endcase
		end
	end

	// stage advance, closing bubbles
	assign adv4 = !vld_s4 || rgb.ready;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign ycc.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= ycc.valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
		end
	end

	// centered samples
	always_comb begin
		if (rng_q == RANGE_FULL) begin
			y_in = samp_t'({1'b0, ycc.data.luma_code});
		end else begin
			y_in = samp_t'({1'b0, ycc.data.luma_code} - LUMA_OFS);
		end
		cb_in = samp_t'({1'b0, ycc.data.cb_code} - CHROMA_ZERO);
		cr_in = samp_t'({1'b0, ycc.data.cr_code} - CHROMA_ZERO);
	end

	// stage 1: samples and coefficient set
	always_ff @(posedge clk) begin
		if (adv1 && ycc.valid) begin
			y_s1 <= y_in;
			cb_s1 <= cb_in;
			cr_s1 <= cr_in;
			cf_s1 <= coef_select(std_q, rng_q);
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			lt_s2 <= y_s1 * $signed({1'b0, cf_s1.luma});
			rcr_s2 <= cr_s1 * $signed({1'b0, cf_s1.rcr});
			bcb_s2 <= cb_s1 * $signed({1'b0, cf_s1.bcb});
			gcr_s2 <= cr_s1 * $signed({1'b0, cf_s1.gcr});
			gcb_s2 <= cb_s1 * $signed({1'b0, cf_s1.gcb});
		end
	end

	// stage 3: channel sums
	always_ff @(posedge clk) begin
		if (adv3 && vld_s2) begin
			accr_s3 <= acc_t'(lt_s2) + acc_t'(rcr_s2);
			accb_s3 <= acc_t'(lt_s2) + acc_t'(bcb_s2);
			accg_s3 <= acc_t'(lt_s2) - acc_t'(gcr_s2) - acc_t'(gcb_s2);
		end
	end

	// round and clamp each channel
	y2r_clamp u_clamp_r (.acc(accr_s3), .value(red_c));
	y2r_clamp u_clamp_g (.acc(accg_s3), .value(green_c));
	y2r_clamp u_clamp_b (.acc(accb_s3), .value(blue_c));

	// stage 4: output register
	always_ff @(posedge clk) begin
		if (adv4 && vld_s3) begin
			rgb_s4.red <= red_c;
			rgb_s4.green <= green_c;
			rgb_s4.blue <= blue_c;
		end
	end

	assign rgb.valid = vld_s4;
	assign rgb.data = rgb_s4;

	// an accepted pixel always lands in stage 1
	`Y2R_ASSERT_NEXT(a_in_to_s1, ycc.valid && ycc.ready, vld_s1,
		"accepted pixel missing from stage 1")

	// a sum that moves on shows up at the output
	`Y2R_ASSERT_NEXT(a_s3_to_out, vld_s3 && adv4, rgb.valid,
		"stage 3 beat lost on the way to the output")

	// a full, stalled pipe pushes back on the input
	`Y2R_ASSERT_IMPLY(a_full_backpressure,
		rgb.valid && !rgb.ready && vld_s3 && vld_s2 && vld_s1, !ycc.ready,
		"input taken while every stage holds a beat")

endmodule

@@ sv/y2r_clamp.sv @@
// ---------------------------------------------------------------------------
// y2r_clamp
// Rounds one fixed-point channel sum half away from zero and clamps it
// to an 8-bit component.
// ---------------------------------------------------------------------------
module y2r_clamp
	import y2r_pkg::*;
(
	input  acc_t       acc,
	output logic [7:0] value
);

	localparam int WHOLE_W = ACC_W - COEF_FRAC_BITS;
	localparam acc_t ROUND_HALF = acc_t'(1) <<< (COEF_FRAC_BITS - 1);

	acc_t biased;
	logic signed [WHOLE_W-1:0] whole;

	// add one half, drop the fraction
	assign biased = acc + ROUND_HALF;
	assign whole = biased[ACC_W-1:COEF_FRAC_BITS];

	// negatives go to zero, overflow to full scale
	always_comb begin
		if (acc[ACC_W-1]) begin
			value = 8'd0;
		end else if (whole > $signed(WHOLE_W'(PIX_MAX))) begin
			value = 8'(PIX_MAX);
		end else begin
			value = whole[7:0];
		end
	end

endmodule
